/* sv/toc_pkg.sv */
package toc_pkg;

	localparam int NUM_OUTPUTS_DEF = 16;
	localparam int OUT_W = 16;
	localparam int IDX_W = 4;
	localparam int TIME_W = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_FIRST    = 3'd0,
		REG_LAST     = 3'd1,
		REG_INTERVAL = 3'd2,
		REG_MODE     = 3'd3,
		REG_ENABLE   = 3'd4
	} reg_idx_t;

	typedef enum logic {
		MODE_PINGPONG = 1'b0,
		MODE_FILL     = 1'b1
	} mode_t;

	typedef struct packed {
		logic [IDX_W-1:0]  first;
		logic [IDX_W-1:0]  last;
		logic [TIME_W-1:0] interval;
		mode_t             mode;
		logic              enable;
	} cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0] mask;
		logic             stepped;
	} res_t;

	localparam logic [IDX_W-1:0]  FIRST_RST = 4'd0;
	localparam logic [IDX_W-1:0]  LAST_RST = 4'd15;
	localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd100;

endpackage

/* sv/toc_core.sv */
module toc_core import toc_pkg::*; #(
	parameter int NumOutputs = NUM_OUTPUTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              clear,
	input  logic              step_en,
	input  logic [TIME_W-1:0] now_ms,
	output res_t              res
);

	// outputs at or above NumOutputs never change, so they get no storage
	localparam int MaskW = (NumOutputs < OUT_W) ? NumOutputs : OUT_W;

	logic [MaskW-1:0]  mask_q;
	logic [IDX_W-1:0]  pos_q;
	logic              loaded_q;
	logic              down_q;
	logic [TIME_W-1:0] last_time_q;

	logic [TIME_W-1:0] elapsed;
	logic              fire;
	logic [OUT_W-1:0]  range_bits;
	logic [OUT_W-1:0]  cur_mask;
	logic [OUT_W-1:0]  pos_bit;
	logic [OUT_W-1:0]  mask_nxt;
	logic [IDX_W-1:0]  pos;
	logic [IDX_W-1:0]  pos_nxt;
	logic              down_nxt;
	logic [MaskW-1:0]  mask_store;

	assign elapsed = now_ms - last_time_q;
	assign fire = cfg.enable && (elapsed > cfg.interval);

	always_comb begin
		for (int i = 0; i < OUT_W; i++) begin
			range_bits[i] = (IDX_W'(i) >= cfg.first) && (IDX_W'(i) <= cfg.last);
		end
	end

	assign cur_mask = OUT_W'(mask_q);
	assign pos = loaded_q ? pos_q : cfg.first;
	assign pos_bit = OUT_W'(1) << pos;

	always_comb begin
		mask_nxt = cur_mask;
		pos_nxt = pos;
		down_nxt = down_q;
		case (cfg.mode)
			MODE_PINGPONG: begin
				if (!down_q) begin
					mask_nxt = cur_mask | pos_bit;
					if (pos < cfg.last) begin
						pos_nxt = pos + IDX_W'(1);
					end else begin
						down_nxt = 1'b1;
					end
				end else begin
					mask_nxt = cur_mask & ~pos_bit;
					if (pos > cfg.first) begin
						pos_nxt = pos - IDX_W'(1);
					end else begin
						down_nxt = 1'b0;
					end
				end
			end
			MODE_FILL: begin
				if (pos < cfg.last) begin
					mask_nxt = cur_mask | pos_bit;
					pos_nxt = pos + IDX_W'(1);
				end else begin
					// top reached: light it, then wipe the range
					mask_nxt = (cur_mask | pos_bit) & ~range_bits;
					pos_nxt = cfg.first;
				end
			end
			default: begin
				mask_nxt = cur_mask;
			end
		endcase
	end

	assign mask_store = MaskW'(mask_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			pos_q <= '0;
			loaded_q <= 1'b0;
			down_q <= 1'b0;
			last_time_q <= '0;
		end else if (clear) begin
			mask_q <= MaskW'(cur_mask & ~range_bits);
			pos_q <= '0;
			loaded_q <= 1'b0;
			down_q <= 1'b0;
			last_time_q <= '0;
		end else if (step_en && fire) begin
			mask_q <= mask_store;
			pos_q <= pos_nxt;
			loaded_q <= 1'b1;
			down_q <= down_nxt;
			last_time_q <= now_ms;
		end
	end

	assign res.mask = fire ? OUT_W'(mask_store) : cur_mask;
	assign res.stepped = fire;

endmodule

/* sv/timed_output_chaser_top.sv */
// Timed output chaser: each word on the item channel is a millisecond timestamp, and each
// one gives exactly one result word with the output mask after that tick and a stepped flag.
// A word is taken every cycle while the result is not stalled; the accepting edge loads the input
// register, and the step logic's output moves on into the result register when that register is
// free or being taken. toc_core updates its state at the edge that loads the result, which sets
// that one-word-per-cycle rate. A stalled result lets one more word into the input register,
// after which item_ready stays low until the result is taken. Registers sit on the APB port
// at 0x00 first_output, 0x04 last_output, 0x08 step_interval, 0x0c chase_mode,
// 0x10 chase_enable; write them only while no word is in flight. Writing 0 to
// chase_enable clears the chased range and restarts the sequence.
module timed_output_chaser_top import toc_pkg::*; #(
	parameter int NumOutputs = NUM_OUTPUTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [TIME_W-1:0] now_ms,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [OUT_W-1:0]  output_mask,
	output logic              stepped
);

	cfg_t              cfg_q;
	reg_idx_t          reg_idx;
	logic              wr_en;
	logic              clear;

	logic              s1_valid_q;
	logic [TIME_W-1:0] now_ms_s1;
	logic              result_valid_q;
	logic [OUT_W-1:0]  mask_q;
	logic              stepped_q;
	logic              advance;
	res_t              core_res;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign clear = wr_en && (reg_idx == REG_ENABLE) && !pwdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first <= FIRST_RST;
			cfg_q.last <= LAST_RST;
			cfg_q.interval <= INTERVAL_RST;
			cfg_q.mode <= MODE_PINGPONG;
			cfg_q.enable <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FIRST:    cfg_q.first <= pwdata[IDX_W-1:0];
				REG_LAST:     cfg_q.last <= pwdata[IDX_W-1:0];
				REG_INTERVAL: cfg_q.interval <= pwdata[TIME_W-1:0];
				REG_MODE:     cfg_q.mode <= mode_t'(pwdata[0]);
				REG_ENABLE:   cfg_q.enable <= pwdata[0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FIRST:    prdata = DATA_W'(cfg_q.first);
			REG_LAST:     prdata = DATA_W'(cfg_q.last);
			REG_INTERVAL: prdata = DATA_W'(cfg_q.interval);
			REG_MODE:     prdata = DATA_W'(cfg_q.mode);
			REG_ENABLE:   prdata = DATA_W'(cfg_q.enable);
			default:      prdata = '0;
		endcase
	end

	// the input register drains whenever the result register is free or being taken
	assign advance = s1_valid_q && (!result_valid_q || result_ready);
	assign item_ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			now_ms_s1 <= now_ms;
		end
		if (advance) begin
			mask_q <= core_res.mask;
			stepped_q <= core_res.stepped;
		end
	end

	toc_core #(
		.NumOutputs(NumOutputs)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.clear   (clear),
		.step_en (advance),
		.now_ms  (now_ms_s1),
		.res     (core_res)
	);

	assign result_valid = result_valid_q;
	assign output_mask = mask_q;
	assign stepped = stepped_q;

	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (s1_valid_q && result_valid_q))
		else $error("item_ready low with a free stage");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_ready && s1_valid_q) |=> (s1_valid_q && $stable(now_ms_s1)))
		else $error("input register changed while the result stalled");

	a_step_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && core_res.stepped) |-> cfg_q.enable)
		else $error("step taken while disabled");

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("result register not loaded after advance");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import toc_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT = 4000;
	localparam int SEGMENTS = 6;
	localparam int SEG_WORDS = 56;
	localparam int LONG_HOLD = 300;
	localparam int PLAN_LEN = 41;

	typedef enum logic {
		ROW_TICK,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		reg_idx_t          idx;
		logic [TIME_W-1:0] val;
		logic              typed;
		logic [OUT_W-1:0]  want_mask;
		logic              want_step;
	} row_t;

	// directed walk: reset values, ping-pong turns, wrap, fill, inverted range, max interval
	row_t plan [PLAN_LEN] = '{
		'{ROW_TICK,  REG_FIRST,    32'hFFFF_FFFF, 1'b1, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_ENABLE,   32'd1,         1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd100,       1'b1, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd101,       1'b1, 16'h0001, 1'b1},
		'{ROW_WRITE, REG_ENABLE,   32'd0,         1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_INTERVAL, 32'd0,         1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_FIRST,    32'd14,        1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_LAST,     32'd15,        1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_ENABLE,   32'd1,         1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd0,         1'b1, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd1,         1'b1, 16'h4000, 1'b1},
		'{ROW_TICK,  REG_FIRST,    32'd2,         1'b1, 16'hC000, 1'b1},
		'{ROW_TICK,  REG_FIRST,    32'd3,         1'b1, 16'h4000, 1'b1},
		'{ROW_TICK,  REG_FIRST,    32'd4,         1'b1, 16'h0000, 1'b1},
		'{ROW_TICK,  REG_FIRST,    32'd5,         1'b1, 16'h4000, 1'b1},
		'{ROW_TICK,  REG_FIRST,    32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd0,         1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_MODE,     32'd1,         1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd10,        1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd20,        1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd30,        1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_ENABLE,   32'd0,         1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd40,        1'b1, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_FIRST,    32'd9,         1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_LAST,     32'd3,         1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_MODE,     32'd0,         1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_ENABLE,   32'd1,         1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd50,        1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd60,        1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd70,        1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_MODE,     32'd1,         1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd80,        1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd90,        1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_ENABLE,   32'd0,         1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_INTERVAL, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_FIRST,    32'd0,         1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_LAST,     32'd15,        1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE, REG_ENABLE,   32'd1,         1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'd1000,      1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK,  REG_FIRST,    32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_ready;
	logic [TIME_W-1:0] now_ms = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic [OUT_W-1:0]  output_mask;
	logic              stepped;

	// chaser state as the block should hold it
	cfg_t              cfg;
	logic [OUT_W-1:0]  lit;
	logic [IDX_W-1:0]  pos;
	logic              pos_loaded;
	logic              descending;
	logic [TIME_W-1:0] last_step_ms;

	res_t              due_words [$];
	res_t              head;
	logic [TIME_W-1:0] clock_ms;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int steps_seen = 0;
	int reg_writes = 0;

	timed_output_chaser_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.now_ms       (now_ms),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.output_mask  (output_mask),
		.stepped      (stepped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_span();
		for (int i = int'(cfg.first); i <= int'(cfg.last); i++)
			lit[i] = 1'b0;
	endfunction

	function automatic void apply_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
		case (idx)
			REG_FIRST: cfg.first = v[IDX_W-1:0];
			REG_LAST: cfg.last = v[IDX_W-1:0];
			REG_INTERVAL: cfg.interval = v[TIME_W-1:0];
			REG_MODE: cfg.mode = mode_t'(v[0]);
			REG_ENABLE: begin
				cfg.enable = v[0];
				if (!v[0]) begin
					clear_span();
					descending = 1'b0;
					last_step_ms = '0;
					pos = '0;
					pos_loaded = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic res_t chaser_tick(input logic [TIME_W-1:0] t);
		res_t              r;
		logic [TIME_W-1:0] elapsed;
		elapsed = t - last_step_ms;
		r.stepped = 1'b0;
		if (cfg.enable && elapsed > cfg.interval) begin
			if (!pos_loaded) begin
				pos = cfg.first;
				pos_loaded = 1'b1;
			end
			if (cfg.mode == MODE_PINGPONG) begin
				// the turn step still lights or clears its position but does not move; only the direction flips
				if (!descending) begin
					lit[pos] = 1'b1;
					if (pos < cfg.last)
						pos = pos + 1'b1;
					else
						descending = 1'b1;
				end else begin
					lit[pos] = 1'b0;
					if (pos > cfg.first)
						pos = pos - 1'b1;
					else
						descending = 1'b0;
				end
			end else begin
				lit[pos] = 1'b1;
				if (pos < cfg.last) begin
					pos = pos + 1'b1;
				end else begin
					clear_span();
					pos = cfg.first;
				end
			end
			last_step_ms = t;
			r.stepped = 1'b1;
		end
		r.mask = lit;
		return r;
	endfunction

	task automatic wait_quiet();
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
		item_valid <= 1'b0;
		wait_quiet();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		apply_reg(idx, v);
		reg_writes++;
	endtask

	task automatic post_tick(input logic [TIME_W-1:0] t, input logic typed, input res_t want);
		res_t guess;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		now_ms <= t;
		do
			@(posedge clk);
		while (!item_ready);
		guess = chaser_tick(t);
		due_words.push_back(typed ? want : guess);
		ticks_sent++;
	endtask

	task automatic shuffle_config();
		logic [DATA_W-1:0] v;
		item_valid <= 1'b0;
		wait_quiet();
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 3))
				0: v = 0;
				1: v = 15;
				default: v = $urandom_range(0, 15);
			endcase
			write_reg(REG_FIRST, v);
		end
		if ($urandom_range(0, 9) < 6) begin
			// mostly a proper range, now and then inverted
			if ($urandom_range(0, 6) != 0)
				v = $urandom_range(int'(cfg.first), 15);
			else
				v = $urandom_range(0, 15);
			write_reg(REG_LAST, v);
		end
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = 32'hFFFF_FFFF;
				2: v = $urandom;
				3: v = $urandom_range(100, 5000);
				default: v = $urandom_range(1, 20);
			endcase
			write_reg(REG_INTERVAL, v);
		end
		if ($urandom_range(0, 1) != 0)
			write_reg(REG_MODE, $urandom_range(0, 1));
		if ($urandom_range(0, 9) < 7)
			write_reg(REG_ENABLE, ($urandom_range(0, 4) != 0) ? 1 : 0);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (due_words.size() == 0) begin
				$error("result word with nothing expected: output_mask %h stepped %0b",
					output_mask, stepped);
				mismatches++;
			end else begin
				head = due_words.pop_front();
				if (output_mask !== head.mask) begin
					$error("output_mask: expected %h, got %h", head.mask, output_mask);
					mismatches++;
				end
				if (stepped !== head.stepped) begin
					$error("stepped: expected %0b, got %0b", head.stepped, stepped);
					mismatches++;
				end
			end
			results_seen++;
			if (stepped === 1'b1)
				steps_seen++;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timed_output_chaser_top regression: fail");
			$finish;
		end
	end

	initial begin
		cfg = '{first: FIRST_RST, last: LAST_RST, interval: INTERVAL_RST,
			mode: MODE_PINGPONG, enable: 1'b0};
		lit = '0;
		pos = '0;
		pos_loaded = 1'b0;
		descending = 1'b0;
		last_step_ms = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].idx, plan[i].val);
			else
				post_tick(plan[i].val, plan[i].typed, {plan[i].want_mask, plan[i].want_step});
		end

		clock_ms = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 57;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 57;
				end
				default: begin
					send_gap_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				shuffle_config();
				// long receiver hold-off while words keep coming, so the input backs up
				if (ph == 0 && seg == 1)
					hold_left = LONG_HOLD;
				repeat (SEG_WORDS) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: clock_ms = clock_ms + cfg.interval + $urandom_range(0, 2);
						6, 7: clock_ms = clock_ms + $urandom_range(0, 3);
						8: clock_ms = clock_ms + $urandom;
						default: clock_ms = $urandom;
					endcase
					post_tick(clock_ms, 1'b0, '0);
				end
			end
		end

		item_valid <= 1'b0;
		wait_quiet();
		$display("covered %0d timestamps and %0d result words (%0d with a step)",
			ticks_sent, results_seen, steps_seen);
		$display("across %0d register writes and four idle/stall mixes", reg_writes);
		if (mismatches == 0)
			$display("timed_output_chaser_top regression: pass");
		else
			$display("timed_output_chaser_top regression: fail");
		$finish;
	end

endmodule
